// File: hdl/wrsi_pkg.sv
package wrsi_pkg;

    // Field and datapath widths.
    localparam int PRICE_BITS    = 32;
    localparam int FRACTION_BITS = 16;
    localparam int ACC_BITS      = 56;
    localparam int PERIOD_BITS   = 8;
    localparam int COUNT_BITS    = 9;
    localparam int RSI_BITS      = 23;
    // Integer bits of the scale 100, so that 100 << FRACTION_BITS fits RSI_BITS.
    localparam int RSI_INT_BITS  = RSI_BITS - FRACTION_BITS;

    // The shift-add multiplier walks an 8-bit multiplier, one bit per step.
    localparam int MUL_STEPS     = PERIOD_BITS;
    localparam int UNIT_BITS     = ACC_BITS + MUL_STEPS;
    localparam int REM_BITS      = ACC_BITS + 1;
    localparam int STEP_BITS     = $clog2(ACC_BITS);

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(14);
    localparam logic [PERIOD_BITS-1:0] RSI_SCALE    = PERIOD_BITS'(100);
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = '1;
    localparam logic [RSI_BITS-1:0]    HUNDRED_FX   = RSI_BITS'(100 << FRACTION_BITS);

    typedef struct packed {
        logic [PRICE_BITS-1:0] close_price;
        logic                  restart;
    } rsi_in_t;

    typedef struct packed {
        logic [RSI_BITS-1:0] rsi_value;
        logic                rsi_valid;
    } rsi_out_t;

    // Handshake between the channel logic and the sequencer.
    typedef struct packed {
        logic start;
        logic out_free;
    } wrsi_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } wrsi_status_t;

    // One operation of the shared adder/subtractor.
    typedef struct packed {
        logic [UNIT_BITS-1:0] a;
        logic [UNIT_BITS-1:0] b;
        logic                 sub;
    } wrsi_op_t;

endpackage

// File: hdl/wilder_rsi_indicator.sv
// Wilder relative strength index over a stream of closing prices. Each input beat
// carries one price in integer ticks and a restart flag, and each one yields exactly
// one result beat: the RSI in Q.16 (0 to 100 points) and a valid flag that is set once
// period price deltas of the current series have been seen. For the first price of a
// series the result beat goes straight to the output; a beat during the seed sums runs
// the two multiplies, and every beat from the seed on also runs the divisions, the sum
// and the ratio (the ratio is skipped when the loss average is zero). One shared 64-bit
// adder/subtractor does all the work, as two 8-step shift-add multiplies and two
// 56-step restoring divisions by the period for the gain and loss averages, the sum of
// the averages, and an 8-step multiply plus a 23-step division for the ratio. The input
// side is not ready while an item is in flight and opens again the cycle after the
// result beat moves into the output register. A stalled result channel holds the
// sequencer until the output register is free. The period register may only be
// written while the block is idle; a period of zero acts as one.
module wilder_rsi_indicator (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Period configuration.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wrsi_pkg::PERIOD_BITS-1:0]  cfg_data,

    // Price input channel.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  wrsi_pkg::rsi_in_t                 s_data,

    // RSI result channel.
    output logic                              m_valid,
    input  logic                              m_ready,
    output wrsi_pkg::rsi_out_t                m_data
);
    import wrsi_pkg::*;

    logic [PERIOD_BITS-1:0] period_reg;
    logic                   m_valid_reg;
    rsi_out_t               m_data_reg;
    wrsi_ctl_t              ctl;
    wrsi_status_t           status;
    rsi_out_t               result;

    // The period register takes a write in every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RESET;
        end else if (cfg_valid) begin
            period_reg <= cfg_data;
        end
    end

    // A new price is taken only while the sequencer is idle.
    assign s_ready      = status.idle;
    assign ctl.start    = s_valid && status.idle;

    // The output register is free when empty or when its beat leaves this cycle.
    assign ctl.out_free = !m_valid_reg || m_ready;

    wrsi_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .in_beat (s_data),
        .period  (period_reg),
        .status  (status),
        .result  (result)
    );

    // Output register: holds a finished beat until the consumer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (status.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (status.done) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: hdl/wrsi_addsub.sv
module wrsi_addsub (
    input  wrsi_pkg::wrsi_op_t                op,
    output logic [wrsi_pkg::UNIT_BITS:0]      res
);
    import wrsi_pkg::*;

    logic [UNIT_BITS:0] b_ext;

    // For a subtraction the top bit of the result is set when a >= b.
    assign b_ext = {1'b0, (op.sub ? ~op.b : op.b)};
    assign res   = {1'b0, op.a} + b_ext + (UNIT_BITS + 1)'(op.sub);

endmodule

// File: hdl/wrsi_engine.sv
module wrsi_engine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  wrsi_pkg::wrsi_ctl_t               ctl,
    input  wrsi_pkg::rsi_in_t                 in_beat,
    input  logic [wrsi_pkg::PERIOD_BITS-1:0]  period,
    output wrsi_pkg::wrsi_status_t            status,
    output wrsi_pkg::rsi_out_t                result
);
    import wrsi_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SUM,
        ST_WRITE
    } state_t;

    typedef enum logic [1:0] {
        PH_GAIN,
        PH_LOSS,
        PH_RSI
    } phase_t;

    state_t                 state_reg;
    phase_t                 phase_reg;

    // Series state.
    logic [PRICE_BITS-1:0]  prev_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [ACC_BITS-1:0]    gain_reg;
    logic [ACC_BITS-1:0]    loss_reg;

    // Working registers of the current item.
    logic [PERIOD_BITS-1:0] p_reg;
    logic [PERIOD_BITS-1:0] factor_reg;
    logic                   skip_reg;
    logic [ACC_BITS-1:0]    move_loss_reg;
    logic [UNIT_BITS-1:0]   prod_reg;
    logic [UNIT_BITS-1:0]   mcand_reg;
    logic [PERIOD_BITS-1:0] mplier_reg;
    logic [REM_BITS-1:0]    rem_reg;
    logic [ACC_BITS-1:0]    quo_reg;
    logic [REM_BITS-1:0]    divisor_reg;
    logic [STEP_BITS-1:0]   cnt_reg;
    rsi_out_t               result_reg;

    logic [PERIOD_BITS-1:0] p_eff;
    logic                   first;
    logic                   price_up;
    logic [PRICE_BITS-1:0]  mag;
    logic [ACC_BITS-1:0]    move_up;
    logic [ACC_BITS-1:0]    move_dn;
    logic [REM_BITS:0]      shifted;
    wrsi_op_t               op;
    logic [UNIT_BITS:0]     res;
    logic [UNIT_BITS-1:0]   prod_next;
    logic [REM_BITS-1:0]    rem_next;
    logic [ACC_BITS-1:0]    quo_next;

    assign p_eff    = (period == '0) ? PERIOD_BITS'(1) : period;
    assign first    = in_beat.restart || (count_reg == '0);
    assign price_up = in_beat.close_price > prev_reg;
    assign mag      = price_up ? (in_beat.close_price - prev_reg)
                               : (prev_reg - in_beat.close_price);
    assign move_up  = price_up
        ? {{(ACC_BITS-PRICE_BITS-FRACTION_BITS){1'b0}}, mag, {FRACTION_BITS{1'b0}}} : '0;
    assign move_dn  = price_up
        ? '0 : {{(ACC_BITS-PRICE_BITS-FRACTION_BITS){1'b0}}, mag, {FRACTION_BITS{1'b0}}};

    assign shifted  = {rem_reg, quo_reg[ACC_BITS-1]};

    // Operand selection for the single shared adder.
    always_comb begin
        op.a   = prod_reg;
        op.b   = mplier_reg[0] ? mcand_reg : '0;
        op.sub = 1'b0;
        unique case (state_reg)
            ST_DIV: begin
                op.a   = UNIT_BITS'(shifted);
                op.b   = UNIT_BITS'(divisor_reg);
                op.sub = 1'b1;
            end
            ST_SUM: begin
                op.a   = UNIT_BITS'(gain_reg);
                op.b   = UNIT_BITS'(loss_reg);
                op.sub = 1'b0;
            end
            ST_IDLE, ST_MUL, ST_WRITE: begin
                op.sub = 1'b0;
            end
            default: begin
                op.sub = 1'b0;
            end
        endcase
    end

    wrsi_addsub u_addsub (
        .op  (op),
        .res (res)
    );

    assign prod_next = res[UNIT_BITS-1:0];
    assign rem_next  = res[UNIT_BITS] ? res[REM_BITS-1:0] : shifted[REM_BITS-1:0];
    assign quo_next  = {quo_reg[ACC_BITS-2:0], res[UNIT_BITS]};

    assign status.idle = (state_reg == ST_IDLE);
    assign status.done = (state_reg == ST_WRITE) && ctl.out_free;
    assign result      = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_GAIN;
            prev_reg   <= '0;
            count_reg  <= '0;
            gain_reg   <= '0;
            loss_reg   <= '0;
            result_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (ctl.start) begin
                        p_reg    <= p_eff;
                        prev_reg <= in_beat.close_price;
                        if (first) begin
                            count_reg  <= COUNT_BITS'(1);
                            gain_reg   <= '0;
                            loss_reg   <= '0;
                            result_reg <= '0;
                            state_reg  <= ST_WRITE;
                        end else begin
                            if (count_reg != COUNT_MAX) begin
                                count_reg <= count_reg + COUNT_BITS'(1);
                            end
                            skip_reg      <= count_reg < {1'b0, p_eff};
                            move_loss_reg <= move_dn;
                            // Seed sums multiply by one, smoothing by period - 1.
                            factor_reg <= (count_reg <= {1'b0, p_eff})
                                          ? PERIOD_BITS'(1) : (p_eff - PERIOD_BITS'(1));
                            mplier_reg <= (count_reg <= {1'b0, p_eff})
                                          ? PERIOD_BITS'(1) : (p_eff - PERIOD_BITS'(1));
                            prod_reg   <= UNIT_BITS'(move_up);
                            mcand_reg  <= UNIT_BITS'(gain_reg);
                            cnt_reg    <= STEP_BITS'(MUL_STEPS - 1);
                            phase_reg  <= PH_GAIN;
                            state_reg  <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    prod_reg   <= prod_next;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg - STEP_BITS'(1);
                    if (cnt_reg == '0) begin
                        priority if (phase_reg == PH_RSI) begin
                            // Preload the high part: the quotient fits RSI_BITS.
                            rem_reg   <= REM_BITS'(prod_next >> RSI_INT_BITS);
                            quo_reg   <= {prod_next[RSI_INT_BITS-1:0],
                                          {(ACC_BITS-RSI_INT_BITS){1'b0}}};
                            cnt_reg   <= STEP_BITS'(RSI_BITS - 1);
                            state_reg <= ST_DIV;
                        end else if (skip_reg && (phase_reg == PH_GAIN)) begin
                            gain_reg   <= prod_next[ACC_BITS-1:0];
                            prod_reg   <= UNIT_BITS'(move_loss_reg);
                            mcand_reg  <= UNIT_BITS'(loss_reg);
                            mplier_reg <= factor_reg;
                            cnt_reg    <= STEP_BITS'(MUL_STEPS - 1);
                            phase_reg  <= PH_LOSS;
                        end else if (skip_reg) begin
                            loss_reg   <= prod_next[ACC_BITS-1:0];
                            result_reg <= '0;
                            state_reg  <= ST_WRITE;
                        end else begin
                            rem_reg     <= '0;
                            quo_reg     <= prod_next[ACC_BITS-1:0];
                            divisor_reg <= REM_BITS'(p_reg);
                            cnt_reg     <= STEP_BITS'(ACC_BITS - 1);
                            state_reg   <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg - STEP_BITS'(1);
                    if (cnt_reg == '0) begin
                        priority if (phase_reg == PH_GAIN) begin
                            gain_reg   <= quo_next;
                            prod_reg   <= UNIT_BITS'(move_loss_reg);
                            mcand_reg  <= UNIT_BITS'(loss_reg);
                            mplier_reg <= factor_reg;
                            cnt_reg    <= STEP_BITS'(MUL_STEPS - 1);
                            phase_reg  <= PH_LOSS;
                            state_reg  <= ST_MUL;
                        end else if (phase_reg == PH_LOSS) begin
                            loss_reg  <= quo_next;
                            state_reg <= ST_SUM;
                        end else begin
                            result_reg.rsi_value <= quo_next[RSI_BITS-1:0];
                            result_reg.rsi_valid <= 1'b1;
                            state_reg            <= ST_WRITE;
                        end
                    end
                end
                ST_SUM: begin
                    if (loss_reg == '0) begin
                        result_reg.rsi_value <= HUNDRED_FX;
                        result_reg.rsi_valid <= 1'b1;
                        state_reg            <= ST_WRITE;
                    end else begin
                        divisor_reg <= res[REM_BITS-1:0];
                        prod_reg    <= '0;
                        mcand_reg   <= UNIT_BITS'(gain_reg);
                        mplier_reg  <= RSI_SCALE;
                        cnt_reg     <= STEP_BITS'(MUL_STEPS - 1);
                        phase_reg   <= PH_RSI;
                        state_reg   <= ST_MUL;
                    end
                end
                ST_WRITE: begin
                    if (ctl.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_rsi_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (status.done && result.rsi_valid) |-> (result.rsi_value <= HUNDRED_FX))
        else $error("RSI result above 100 points");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (status.done && !result.rsi_valid) |-> (result.rsi_value == '0))
        else $error("invalid RSI result carries a nonzero value");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (divisor_reg != '0))
        else $error("division by zero in the shared unit");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < divisor_reg))
        else $error("division remainder not below divisor");
`endif

endmodule
